### rtl/refinement_marking_selector_top_assert.svh
// ----------------------------------------------------------------------------
// Refinement marking selector assertion macros
// Concurrent checks on the top level, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef REFINEMENT_MARKING_SELECTOR_TOP_ASSERT_SVH
`define REFINEMENT_MARKING_SELECTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define RMS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rms assertion failed");
// Next-cycle implication
`define RMS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rms assertion failed");
`else
`define RMS_ASSERT_IMP(lbl, ante, cons)
`define RMS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// Shared constants, codes and control types of the refinement marking selector.
// ----------------------------------------------------------------------------
package rms_pkg;

	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int VALUE_BITS_DEF   = 24;

	localparam int ERR_W   = 24;
	localparam int QIDX_W  = 10;
	localparam int FRAC_W  = 17;
	localparam int MODE_W  = 2;
	localparam int SQ_W    = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;

	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRACTION = 1'b1;

	// Marking modes
	localparam logic [MODE_W-1:0] MODE_NONE            = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIXED_FRACTION  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FIXED_THRESHOLD = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BULK            = 2'd3;

	// Request actions
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QUERY,
		ST_SETTLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_SUM,
		ST_SWEEP,
		ST_RANK_CHECK,
		ST_SCAN,
		ST_PICK,
		ST_ACC
	} state_t;

	typedef struct packed {
		logic load_en;
		logic query_en;
		logic mul_lo;
		logic mul_hi;
		logic mul_sum;
		logic rank_init;
		logic walk_start;
		logic sweep;
		logic scan;
		logic pick;
		logic acc;
		logic out_load;
		logic set_done;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              walk_done;
		logic              rank_end;
		logic              out_free;
	} stat_t;

endpackage

### rtl/refinement_marking_selector_top.sv
// ----------------------------------------------------------------------------
// refinement_marking_selector_top
// Refinement marking selector: loads error values, marks elements by fixed
// fraction, fixed threshold or bulk criterion, and answers flag queries.
// ----------------------------------------------------------------------------
// A load request is taken while in_ready is high, so loads stream one per cycle
// while no marking pass or query holds in_ready low. A query reads its flag, then
// loads the result register once that register can accept, and requests wait
// until then. The load that ends a set starts a marking pass with in_ready low:
// it sets up thresholds and sweeps the flag store, then, in rank modes, finds
// each marked element by a full walk of the value store through its single read
// port.
`include "refinement_marking_selector_top_assert.svh"

module refinement_marking_selector_top #(
	parameter int MAX_ELEMENTS = rms_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS   = rms_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rms_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [rms_pkg::ERR_W-1:0]      error_value,
	input  logic                           last_value,
	input  logic [rms_pkg::QIDX_W-1:0]     query_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           refine,
	output logic                           bad_index
);

	rms_pkg::cmd_t  cmd;
	rms_pkg::stat_t stat;

	// Sequencer
	rms_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.action     (action),
		.last_value (last_value),
		.stat       (stat),
		.in_ready   (in_ready),
		.cmd        (cmd)
	);

	// Datapath
	rms_dpath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.VALUE_BITS   (VALUE_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.error_value (error_value),
		.query_index (query_index),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.refine      (refine),
		.bad_index   (bad_index)
	);

	// A bad index never reports a marked element
	`RMS_ASSERT_IMP(a_bad_not_marked, out_valid, !(refine && bad_index))
	// A closing load starts the marking pass and stalls requests
	`RMS_ASSERT_NXT(a_last_stalls, in_valid && in_ready && !action && last_value, !in_ready)
	// A query stalls requests while its flag is read
	`RMS_ASSERT_NXT(a_query_stalls, in_valid && in_ready && action, !in_ready)

endmodule

### rtl/rms_ctrl.sv
// ----------------------------------------------------------------------------
// rms_ctrl
// Sequencer: takes requests, runs the marking pass and steers the datapath.
// ----------------------------------------------------------------------------
module rms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           action,
	input  logic           last_value,
	input  rms_pkg::stat_t stat,
	output logic           in_ready,
	output rms_pkg::cmd_t  cmd
);

	rms_pkg::state_t state_q, state_nxt;
	logic            rank_modes;

	assign rank_modes = (stat.mode == rms_pkg::MODE_FIXED_FRACTION) ||
		(stat.mode == rms_pkg::MODE_BULK);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rms_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rms_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (action == rms_pkg::ACT_QUERY) begin
						state_nxt = rms_pkg::ST_QUERY;
					end else if (last_value) begin
						state_nxt = rms_pkg::ST_SETTLE;
					end
				end
			end
			rms_pkg::ST_QUERY: begin
				if (stat.out_free) begin
					state_nxt = rms_pkg::ST_IDLE;
				end
			end
			rms_pkg::ST_SETTLE:  state_nxt = rms_pkg::ST_MUL_LO;
			rms_pkg::ST_MUL_LO:  state_nxt = rms_pkg::ST_MUL_HI;
			rms_pkg::ST_MUL_HI:  state_nxt = rms_pkg::ST_MUL_SUM;
			rms_pkg::ST_MUL_SUM: state_nxt = rms_pkg::ST_SWEEP;
			rms_pkg::ST_SWEEP: begin
				if (stat.walk_done) begin
					state_nxt = rank_modes ? rms_pkg::ST_RANK_CHECK : rms_pkg::ST_IDLE;
				end
			end
			rms_pkg::ST_RANK_CHECK: begin
				state_nxt = stat.rank_end ? rms_pkg::ST_IDLE : rms_pkg::ST_SCAN;
			end
			rms_pkg::ST_SCAN: begin
				if (stat.walk_done) begin
					state_nxt = rms_pkg::ST_PICK;
				end
			end
			rms_pkg::ST_PICK: state_nxt = rms_pkg::ST_ACC;
			rms_pkg::ST_ACC:  state_nxt = rms_pkg::ST_RANK_CHECK;
			default:          state_nxt = rms_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rms_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_en  = in_valid && (action == rms_pkg::ACT_LOAD);
				cmd.query_en = in_valid && (action == rms_pkg::ACT_QUERY);
			end
			rms_pkg::ST_QUERY: cmd.out_load = stat.out_free;
			rms_pkg::ST_SETTLE: ;
			rms_pkg::ST_MUL_LO: begin
				cmd.mul_lo    = 1'b1;
				cmd.rank_init = 1'b1;
			end
			rms_pkg::ST_MUL_HI:  cmd.mul_hi = 1'b1;
			rms_pkg::ST_MUL_SUM: begin
				cmd.mul_sum    = 1'b1;
				cmd.walk_start = 1'b1;
			end
			rms_pkg::ST_SWEEP: begin
				cmd.sweep    = 1'b1;
				cmd.set_done = stat.walk_done && !rank_modes;
			end
			rms_pkg::ST_RANK_CHECK: begin
				cmd.set_done   = stat.rank_end;
				cmd.walk_start = !stat.rank_end;
			end
			rms_pkg::ST_SCAN: cmd.scan = 1'b1;
			rms_pkg::ST_PICK: cmd.pick = 1'b1;
			rms_pkg::ST_ACC:  cmd.acc  = 1'b1;
			default: ;
		endcase
	end

endmodule

### rtl/rms_dpath.sv
// ----------------------------------------------------------------------------
// rms_dpath
// Value and flag stores, set statistics, marking thresholds, rank search and
// the result register.
// ----------------------------------------------------------------------------
module rms_dpath #(
	parameter int MAX_ELEMENTS = rms_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS   = rms_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rms_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [rms_pkg::ERR_W-1:0]       error_value,
	input  logic [rms_pkg::QIDX_W-1:0]      query_index,
	input  logic                            out_ready,
	input  rms_pkg::cmd_t                   cmd,
	output rms_pkg::stat_t                  stat,
	output logic                            out_valid,
	output logic                            refine,
	output logic                            bad_index
);

	localparam int VB   = VALUE_BITS;
	localparam int IW   = $clog2(MAX_ELEMENTS);
	localparam int CW   = $clog2(MAX_ELEMENTS + 1);
	localparam int FW   = rms_pkg::FRAC_W;
	localparam int SQW  = rms_pkg::SQ_W;
	localparam int QW   = rms_pkg::QIDX_W;
	localparam int EW   = rms_pkg::ERR_W;
	localparam int PW   = 32 + FW;
	localparam int TW   = SQW + FW;
	localparam int THW  = VB + FW;
	localparam int KW   = FW + CW;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

	// Configuration
	logic [rms_pkg::MODE_W-1:0] mode_q;
	logic [FW-1:0]              frac_q;

	// Set statistics
	logic [CW-1:0]  count_q;
	logic           complete_q;
	logic [VB-1:0]  max_q;
	logic [SQW-1:0] total_q;
	logic [2*VB-1:0] sq_s1;
	logic           sq_vld_s1;

	// Thresholds
	logic [PW-1:0]  p_lo_q, p_hi_q;
	logic [TW-1:0]  t_q;
	logic [THW-1:0] thr_q;
	logic [CW-1:0]  k_q;
	logic [KW-1:0]  k_prod;

	// Walk over the value store
	logic [CW-1:0]  ptr_q;
	logic           rd_vld_s1;
	logic [IW-1:0]  rd_idx_s1;
	logic [VB-1:0]  v_rd_s1;

	// Rank search
	logic [VB-1:0]  best_v_q, prev_v_q;
	logic [IW-1:0]  best_i_q, prev_i_q;
	logic           best_ok_q, have_prev_q;
	logic [CW-1:0]  rank_q;
	logic [SQW-1:0] marked_q;
	logic [2*VB-1:0] sq_pick_s1;
	logic           cond_ok;
	logic           after_prev, better, over_thr;

	// Query and result
	logic           flag_rd_q, bad_s1;
	logic           out_valid_q, refine_q, bad_q;

	// Stores
	logic [VB-1:0]  vmem [MAX_ELEMENTS];
	logic           fmem [MAX_ELEMENTS];
	logic           fwe;
	logic [IW-1:0]  fwa;
	logic           fwd;

	logic [VB+EW-1:0] v_wide;
	logic [VB-1:0]    v_in;
	logic [CW+QW-1:0] idx_ext, cnt_ext;
	logic             q_bad;
	logic [SQW:0]     tot_sum, mark_sum;

	assign v_wide  = {{VB{1'b0}}, error_value};
	assign v_in    = v_wide[VB-1:0];
	assign idx_ext = {{CW{1'b0}}, query_index};
	assign cnt_ext = {{QW{1'b0}}, count_q};
	assign q_bad   = !complete_q || (idx_ext >= cnt_ext);

	assign tot_sum  = {1'b0, total_q} + {{(SQW+1-2*VB){1'b0}}, sq_s1};
	assign mark_sum = {1'b0, marked_q} + {{(SQW+1-2*VB){1'b0}}, sq_pick_s1};
	assign k_prod   = frac_q * count_q;
	assign cond_ok  = {1'b0, marked_q, 16'd0} < t_q;

	assign after_prev = !have_prev_q || (v_rd_s1 < prev_v_q) ||
		((v_rd_s1 == prev_v_q) && (rd_idx_s1 > prev_i_q));
	assign better     = !best_ok_q || (v_rd_s1 > best_v_q);
	assign over_thr   = {1'b0, v_rd_s1, 16'd0} > thr_q;

	// Configuration registers, fraction saturates at one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rms_pkg::MODE_NONE;
			frac_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rms_pkg::CFG_MODE:     mode_q <= cfg_data[rms_pkg::MODE_W-1:0];
				rms_pkg::CFG_FRACTION: frac_q <= (cfg_data > rms_pkg::FRAC_ONE) ?
					rms_pkg::FRAC_ONE : cfg_data[FW-1:0];
				default: ;
			endcase
		end
	end

	// Set statistics: count, maximum, completion, square total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			complete_q <= 1'b0;
			max_q      <= '0;
			total_q    <= '0;
			sq_vld_s1  <= 1'b0;
		end else begin
			sq_vld_s1 <= 1'b0;
			if (cmd.load_en) begin
				if (complete_q) begin
					complete_q <= 1'b0;
					total_q    <= '0;
					count_q    <= CW'(1);
					max_q      <= v_in;
					sq_vld_s1  <= 1'b1;
				end else if (count_q < MAX_CNT) begin
					count_q   <= count_q + CW'(1);
					sq_vld_s1 <= 1'b1;
					if (v_in > max_q) begin
						max_q <= v_in;
					end
				end
			end
			if (sq_vld_s1) begin
				total_q <= tot_sum[SQW] ? {SQW{1'b1}} : tot_sum[SQW-1:0];
			end
			if (cmd.set_done) begin
				complete_q <= 1'b1;
			end
		end
	end

	// Square of the loaded value
	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			sq_s1 <= v_in * v_in;
		end
	end

	// Value store: write on load, read along the walk
	always_ff @(posedge clk) begin
		if (cmd.load_en && (complete_q || (count_q < MAX_CNT))) begin
			vmem[complete_q ? '0 : count_q[IW-1:0]] <= v_in;
		end
		if ((cmd.sweep || cmd.scan) && (ptr_q < count_q)) begin
			v_rd_s1   <= vmem[ptr_q[IW-1:0]];
			rd_idx_s1 <= ptr_q[IW-1:0];
		end
	end

	// Marking thresholds, wide product split into low and high halves
	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			p_lo_q <= total_q[31:0] * frac_q;
			thr_q  <= frac_q * max_q;
			k_q    <= k_prod[16+CW-1:16];
		end
		if (cmd.mul_hi) begin
			p_hi_q <= total_q[SQW-1:32] * frac_q;
		end
		if (cmd.mul_sum) begin
			t_q <= {p_hi_q, 32'd0} + {32'd0, p_lo_q};
		end
	end

	// Walk pointer and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (cmd.walk_start) begin
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (cmd.sweep || cmd.scan) begin
			rd_vld_s1 <= ptr_q < count_q;
			if (ptr_q < count_q) begin
				ptr_q <= ptr_q + CW'(1);
			end
		end
	end

	// Rank search: best remaining element after the previous pick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_ok_q   <= 1'b0;
			have_prev_q <= 1'b0;
			rank_q      <= '0;
			marked_q    <= '0;
		end else begin
			if (cmd.rank_init) begin
				have_prev_q <= 1'b0;
				rank_q      <= '0;
				marked_q    <= '0;
			end
			if (cmd.walk_start) begin
				best_ok_q <= 1'b0;
			end else if (cmd.scan && rd_vld_s1 && after_prev && better) begin
				best_ok_q <= 1'b1;
			end
			if (cmd.pick) begin
				have_prev_q <= 1'b1;
				rank_q      <= rank_q + CW'(1);
			end
			if (cmd.acc) begin
				marked_q <= mark_sum[SQW] ? {SQW{1'b1}} : mark_sum[SQW-1:0];
			end
		end
	end

	// Rank search payload
	always_ff @(posedge clk) begin
		if (cmd.scan && rd_vld_s1 && after_prev && better) begin
			best_v_q <= v_rd_s1;
			best_i_q <= rd_idx_s1;
		end
		if (cmd.pick) begin
			prev_v_q   <= best_v_q;
			prev_i_q   <= best_i_q;
			sq_pick_s1 <= best_v_q * best_v_q;
		end
	end

	// Flag store write port: sweep clears or thresholds, pick sets
	always_comb begin
		fwe = 1'b0;
		fwa = rd_idx_s1;
		fwd = 1'b0;
		if (cmd.sweep && rd_vld_s1) begin
			fwe = 1'b1;
			fwd = (mode_q == rms_pkg::MODE_FIXED_THRESHOLD) && over_thr;
		end else if (cmd.pick) begin
			fwe = 1'b1;
			fwa = best_i_q;
			fwd = 1'b1;
		end
	end

	// Flag store
	always_ff @(posedge clk) begin
		if (fwe) begin
			fmem[fwa] <= fwd;
		end
		if (cmd.query_en) begin
			flag_rd_q <= fmem[idx_ext[IW-1:0]];
			bad_s1    <= q_bad;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			refine_q <= !bad_s1 && flag_rd_q;
			bad_q    <= bad_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign refine    = refine_q;
	assign bad_index = bad_q;

	// Status to the sequencer
	always_comb begin
		stat.mode      = mode_q;
		stat.walk_done = (ptr_q == count_q) && !rd_vld_s1;
		stat.rank_end  = (mode_q == rms_pkg::MODE_BULK) ?
			((rank_q == count_q) || !cond_ok) : (rank_q >= k_q);
		stat.out_free  = !out_valid_q || out_ready;
	end

endmodule
